FILE: rtl/snd_pkg.sv
// Shared types, widths and constants of the 3D simplex noise pipeline.
// No dependencies; every other rtl file imports this package.
`default_nettype none
package snd_pkg;

	localparam int COORD_W  = 32;
	localparam int SUM_W    = 34;
	localparam int INT_FRAC = 28;
	localparam int OFS_W    = 30;
	localparam int SQ_W     = 60;
	localparam int T_W      = 28;
	localparam int G_W      = 32;
	localparam int PROD_W   = 61;
	localparam int TERM_W   = PROD_W - (INT_FRAC - 3);
	localparam int ACC_W    = TERM_W + 2;
	localparam int OUT_W    = 19;
	localparam int NSTAGE   = 15;

	localparam logic [T_W-1:0] T_LIMIT = 28'd161061274;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic [1:0] hi;
		logic [1:0] mid;
	} order_t;

	localparam logic [5:0] HASH_TAB [8] = '{6'd21, 6'd56, 6'd50, 6'd44, 6'd13, 6'd19, 6'd7, 6'd42};

	function automatic logic [5:0] tab_pick(input logic a, input logic b, input logic c);
		return HASH_TAB[{a, b, c}];
	endfunction

	// low six bits of the bit-shuffle hash
	function automatic logic [5:0] hash6(input logic [7:0] p, input logic [7:0] q,
			input logic [7:0] r);
		logic [5:0] s;
		s = tab_pick(p[0], q[0], r[0]) + tab_pick(q[1], r[1], p[1])
			+ tab_pick(r[2], p[2], q[2]) + tab_pick(p[3], q[3], r[3])
			+ tab_pick(q[4], r[4], p[4]) + tab_pick(r[5], p[5], q[5])
			+ tab_pick(p[6], q[6], r[6]) + tab_pick(q[7], r[7], p[7]);
		return s;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/snd_skew.sv
// Skew stages s1 to s4: floor of sum/3, lattice cell and fractional offsets.
// Depends on snd_pkg.
`default_nettype none
module snd_skew #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic [3:0]                          en,
	input  wire logic signed [snd_pkg::COORD_W-1:0]  coord_x,
	input  wire logic signed [snd_pkg::COORD_W-1:0]  coord_y,
	input  wire logic signed [snd_pkg::COORD_W-1:0]  coord_z,
	output logic [FRAC_BITS-1:0]                     fx,
	output logic [FRAC_BITS-1:0]                     fy,
	output logic [FRAC_BITS-1:0]                     fz,
	output logic [7:0]                               cx,
	output logic [7:0]                               cy,
	output logic [7:0]                               cz,
	output logic [1:0]                               rem
);
	import snd_pkg::*;

	localparam logic [20:0] DIV3_M = 21'd699051;
	localparam logic [SUM_W-1:0] SUM_OFS = 34'h1_8000_0000;
	localparam logic signed [SUM_W-1:0] HALF = 34'sh0_8000_0000;

	// exact floor(n/3) for n below 3*2^17
	function automatic logic [16:0] div3_19(input logic [18:0] n);
		logic [39:0] p;
		p = 40'(n) * 40'(DIV3_M);
		return p[37:21];
	endfunction

	logic signed [SUM_W-1:0] sum_d;
	logic [SUM_W-1:0] n_d;
	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2, x_s3, y_s3, z_s3;
	logic [SUM_W-1:0] n_s1, n_s2;
	logic [16:0] qa_s2, qa_s3, qv_s3;
	logic [18:0] v_s3;
	logic [1:0] q3a, ra_d, q3v, rem_d;
	logic [18:0] v_d;
	logic signed [SUM_W-1:0] third_d, skx_d, sky_d, skz_d;

	assign sum_d = {{2{coord_x[31]}}, coord_x} + {{2{coord_y[31]}}, coord_y}
		+ {{2{coord_z[31]}}, coord_z};
	assign n_d = $unsigned(sum_d) + SUM_OFS;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1 <= coord_x;
			y_s1 <= coord_y;
			z_s1 <= coord_z;
			n_s1 <= n_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			z_s2  <= z_s1;
			n_s2  <= n_s1;
			qa_s2 <= div3_19({2'b00, n_s1[33:17]});
		end
	end

	assign q3a  = 2'({qa_s2[0], 1'b0} + qa_s2[1:0]);
	assign ra_d = n_s2[18:17] - q3a;
	assign v_d  = {ra_d, n_s2[16:0]};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			x_s3  <= x_s2;
			y_s3  <= y_s2;
			z_s3  <= z_s2;
			qa_s3 <= qa_s2;
			v_s3  <= v_d;
			qv_s3 <= div3_19(v_d);
		end
	end

	assign q3v     = 2'({qv_s3[0], 1'b0} + qv_s3[1:0]);
	assign rem_d   = v_s3[1:0] - q3v;
	assign third_d = $signed({qa_s3, 17'd0} + {17'd0, qv_s3}) - HALF;
	assign skx_d   = {{2{x_s3[31]}}, x_s3} + third_d;
	assign sky_d   = {{2{y_s3[31]}}, y_s3} + third_d;
	assign skz_d   = {{2{z_s3[31]}}, z_s3} + third_d;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			fx  <= skx_d[FRAC_BITS-1:0];
			fy  <= sky_d[FRAC_BITS-1:0];
			fz  <= skz_d[FRAC_BITS-1:0];
			cx  <= skx_d[FRAC_BITS+7:FRAC_BITS];
			cy  <= sky_d[FRAC_BITS+7:FRAC_BITS];
			cz  <= skz_d[FRAC_BITS+7:FRAC_BITS];
			rem <= rem_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/snd_offset.sv
// Stages s5 and s6: corner order and the unskewed offsets divided by three.
// Depends on snd_pkg.
`default_nettype none
module snd_offset #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic [1:0]                  en,
	input  wire logic [FRAC_BITS-1:0]        fx,
	input  wire logic [FRAC_BITS-1:0]        fy,
	input  wire logic [FRAC_BITS-1:0]        fz,
	input  wire logic [7:0]                  cx,
	input  wire logic [7:0]                  cy,
	input  wire logic [7:0]                  cz,
	input  wire logic [1:0]                  rem,
	output logic signed [FRAC_BITS+2:0]      qd_x,
	output logic signed [FRAC_BITS+2:0]      qd_y,
	output logic signed [FRAC_BITS+2:0]      qd_z,
	output logic [1:0]                       rd,
	output snd_pkg::order_t                  ord,
	output logic [7:0]                       cx_o,
	output logic [7:0]                       cy_o,
	output logic [7:0]                       cz_o
);
	import snd_pkg::*;

	localparam int NW = FRAC_BITS + 2;
	localparam int QW = FRAC_BITS + 3;
	localparam int E  = NW + 1;
	localparam logic [NW-1:0] RCP = NW'((2 ** E + 2) / 3);

	logic [NW-1:0] n2_d, n2_s5;
	logic [2*NW-1:0] prod_d;
	logic [FRAC_BITS:0] qs_s5;
	logic [FRAC_BITS-1:0] fx_s5, fy_s5, fz_s5;
	logic [7:0] cx_s5, cy_s5, cz_s5;
	logic ge_xz, ge_xy, ge_yz;
	logic [1:0] hi_d, lo_d;
	logic [2:0] mid_n;
	order_t ord_d, ord_s5;
	logic [1:0] rd_d;

	assign n2_d   = NW'(fx) + NW'(fy) + NW'(fz) + NW'(2) - NW'(rem);
	assign prod_d = (2*NW)'(n2_d) * (2*NW)'(RCP);

	assign ge_xz = fx >= fz;
	assign ge_xy = fx >= fy;
	assign ge_yz = fy >= fz;

	always_comb begin
		if (ge_xz) hi_d = ge_xy ? AXIS_X : AXIS_Y;
		else hi_d = ge_yz ? AXIS_Y : AXIS_Z;
		if (!ge_xz) lo_d = !ge_xy ? AXIS_X : AXIS_Y;
		else lo_d = !ge_yz ? AXIS_Y : AXIS_Z;
		mid_n = 3'd3 - {1'b0, hi_d} - {1'b0, lo_d};
		ord_d.hi = hi_d;
		ord_d.mid = (mid_n > 3'd2) ? AXIS_Z : mid_n[1:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			n2_s5  <= n2_d;
			qs_s5  <= prod_d[E +: FRAC_BITS+1];
			fx_s5  <= fx;
			fy_s5  <= fy;
			fz_s5  <= fz;
			cx_s5  <= cx;
			cy_s5  <= cy;
			cz_s5  <= cz;
			ord_s5 <= ord_d;
		end
	end

	// remainder is 0..2, so two bits of arithmetic suffice
	assign rd_d = 2'({qs_s5[0], 1'b0} + qs_s5[1:0] + 2'd2 - n2_s5[1:0]);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			qd_x <= $signed({2'b00, fx_s5, 1'b0} - {2'b00, qs_s5});
			qd_y <= $signed({2'b00, fy_s5, 1'b0} - {2'b00, qs_s5});
			qd_z <= $signed({2'b00, fz_s5, 1'b0} - {2'b00, qs_s5});
			rd   <= rd_d;
			ord  <= ord_s5;
			cx_o <= cx_s5;
			cy_o <= cy_s5;
			cz_o <= cz_s5;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/snd_corner.sv
// Stages s7 to s13 of one simplex corner: offsets, hash, gradient, falloff, term.
// Depends on snd_pkg.
`default_nettype none
module snd_corner #(
	parameter int FRAC_BITS = 16,
	parameter int CORNER = 0
) (
	input  wire logic                             clk,
	input  wire logic [6:0]                       en,
	input  wire logic signed [FRAC_BITS+2:0]      qd_x,
	input  wire logic signed [FRAC_BITS+2:0]      qd_y,
	input  wire logic signed [FRAC_BITS+2:0]      qd_z,
	input  wire logic [1:0]                       rd,
	input  wire snd_pkg::order_t                  ord,
	input  wire logic [7:0]                       cx,
	input  wire logic [7:0]                       cy,
	input  wire logic [7:0]                       cz,
	output logic signed [snd_pkg::TERM_W-1:0]     term
);
	import snd_pkg::*;

	localparam int AW = FRAC_BITS + 3;
	localparam int U  = 2 ** FRAC_BITS;
	localparam int CU = CORNER * U;
	localparam int K  = INT_FRAC - 1 - FRAC_BITS;
	localparam logic signed [AW-1:0] TWO_U = AW'(2 * U);
	localparam logic signed [AW-1:0] QC    = AW'(CU / 3);
	localparam logic [2:0] RC              = 3'(CU % 3);
	localparam logic [K-1:0] C1            = K'((2 ** K) / 3);
	localparam logic [K-1:0] C2            = K'((2 ** (K + 1)) / 3);

	function automatic logic signed [OFS_W-1:0] ofs(input logic signed [AW-1:0] qd,
			input logic s, input logic c, input logic [1:0] rm);
		logic signed [AW-1:0] a;
		logic [K-1:0] lo;
		a = qd - (s ? TWO_U : '0) + QC + $signed(AW'(c));
		case (rm)
			2'd1: lo = C1;
			2'd2: lo = C2;
			default: lo = '0;
		endcase
		return $signed({a, lo});
	endfunction

	logic [2:0] st;
	logic [2:0] rs;
	logic carry;
	logic [1:0] rm;
	logic signed [OFS_W-1:0] ox_s7, oy_s7, oz_s7;
	logic [5:0] h_s7;
	logic signed [G_W-1:0] gx, gy, gz, p, q, r, g_d;
	logic signed [G_W-1:0] g_s8, g_s9, g_s10, g_s11;
	logic signed [SQ_W-1:0] sqx_s8, sqy_s8, sqz_s8;
	logic [SQ_W-1:0] sq_d;
	logic [T_W-1:0] t_s9, t2_s10, t4_s11;
	logic [2*T_W-1:0] tt_d, t4_d;
	logic signed [PROD_W-1:0] prod_s12;

	always_comb begin
		case (CORNER)
			0: st = 3'b000;
			1: st = 3'b001 << ord.hi;
			2: st = (3'b001 << ord.hi) | (3'b001 << ord.mid);
			default: st = 3'b111;
		endcase
		rs = 3'(rd) + RC;
		carry = rs >= 3'd3;
		rm = carry ? 2'(rs - 3'd3) : rs[1:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ox_s7 <= ofs(qd_x, st[0], carry, rm);
			oy_s7 <= ofs(qd_y, st[1], carry, rm);
			oz_s7 <= ofs(qd_z, st[2], carry, rm);
			h_s7  <= hash6(cx + 8'(st[0]), cy + 8'(st[1]), cz + 8'(st[2]));
		end
	end

	// gradient select and signs
	always_comb begin
		gx = G_W'(ox_s7);
		gy = G_W'(oy_s7);
		gz = G_W'(oz_s7);
		case (h_s7[1:0])
			2'd1: begin p = gx; q = gy; r = gz; end
			2'd2: begin p = gy; q = gz; r = gx; end
			default: begin p = gz; q = gx; r = gy; end
		endcase
		if (h_s7[5] == h_s7[3]) p = -p;
		if (h_s7[5] == h_s7[4]) q = -q;
		if (h_s7[5] != (h_s7[4] ^ h_s7[3])) r = -r;
		if (h_s7[1:0] == 2'd0) g_d = p + q + r;
		else if (!h_s7[2]) g_d = p + q;
		else g_d = p + r;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sqx_s8 <= ox_s7 * ox_s7;
			sqy_s8 <= oy_s7 * oy_s7;
			sqz_s8 <= oz_s7 * oz_s7;
			g_s8   <= g_d;
		end
	end

	assign sq_d = $unsigned(sqx_s8) + $unsigned(sqy_s8) + $unsigned(sqz_s8);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t_s9 <= (sq_d[59:28] > 32'(T_LIMIT)) ? '0 : T_LIMIT - sq_d[55:28];
			g_s9 <= g_s8;
		end
	end

	assign tt_d = (2*T_W)'(t_s9) * (2*T_W)'(t_s9);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			t2_s10 <= tt_d[2*T_W-1:INT_FRAC];
			g_s10  <= g_s9;
		end
	end

	assign t4_d = (2*T_W)'(t2_s10) * (2*T_W)'(t2_s10);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			t4_s11 <= t4_d[2*T_W-1:INT_FRAC];
			g_s11  <= g_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			prod_s12 <= $signed({1'b0, t4_s11}) * g_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			term <= prod_s12[PROD_W-1:INT_FRAC-3];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/simplex_noise_3d_top.sv
// Top level of the 3D simplex noise pipeline: control, corner sum and saturation.
// Depends on snd_pkg, snd_skew, snd_offset and snd_corner.
//
//   channel | data                      | handshake
//   --------+---------------------------+--------------------------
//   coord   | coord_x, coord_y, coord_z | coord_valid, coord_stall
//   noise   | noise_value               | noise_valid, noise_stall
//
// Fifteen register stages; one request enters per cycle while coord_stall is low.
// Four corner lanes run side by side; their multipliers set the stage depth.
// Reset clears the valid bits only. A stall holds only the full stages at the
// output end, so empty stages further up keep taking requests.
`default_nettype none
module simplex_noise_3d_top #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                coord_valid,
	output logic                                     coord_stall,
	input  wire logic signed [snd_pkg::COORD_W-1:0]  coord_x,
	input  wire logic signed [snd_pkg::COORD_W-1:0]  coord_y,
	input  wire logic signed [snd_pkg::COORD_W-1:0]  coord_z,
	output logic                                     noise_valid,
	input  wire logic                                noise_stall,
	output logic signed [snd_pkg::OUT_W-1:0]         noise_value
);
	import snd_pkg::*;

	localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(262143);
	localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(262144);

	logic [NSTAGE-1:0] v_q;
	logic [NSTAGE-1:0] en;

	logic [FRAC_BITS-1:0] fx, fy, fz;
	logic [7:0] cx, cy, cz, cx6, cy6, cz6;
	logic [1:0] rem, rd;
	logic signed [FRAC_BITS+2:0] qd_x, qd_y, qd_z;
	order_t ord;
	logic signed [TERM_W-1:0] term [4];
	logic signed [ACC_W-1:0] acc_s14, sh_d;
	logic signed [OUT_W-1:0] res_s15;

	for (genvar k = 0; k < NSTAGE; k++) begin : g_en
		assign en[k] = !(noise_stall && (&v_q[NSTAGE-1:k]));
	end

	assign coord_stall = !en[0];
	assign noise_valid = v_q[NSTAGE-1];
	assign noise_value = res_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= coord_valid;
			for (int k = 1; k < NSTAGE; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	snd_skew #(.FRAC_BITS(FRAC_BITS)) u_skew (
		.clk(clk), .en(en[3:0]),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.fx(fx), .fy(fy), .fz(fz), .cx(cx), .cy(cy), .cz(cz), .rem(rem)
	);

	snd_offset #(.FRAC_BITS(FRAC_BITS)) u_offset (
		.clk(clk), .en(en[5:4]),
		.fx(fx), .fy(fy), .fz(fz), .cx(cx), .cy(cy), .cz(cz), .rem(rem),
		.qd_x(qd_x), .qd_y(qd_y), .qd_z(qd_z), .rd(rd), .ord(ord),
		.cx_o(cx6), .cy_o(cy6), .cz_o(cz6)
	);

	for (genvar c = 0; c < 4; c++) begin : g_corner
		snd_corner #(.FRAC_BITS(FRAC_BITS), .CORNER(c)) u_corner (
			.clk(clk), .en(en[12:6]),
			.qd_x(qd_x), .qd_y(qd_y), .qd_z(qd_z), .rd(rd), .ord(ord),
			.cx(cx6), .cy(cy6), .cz(cz6), .term(term[c])
		);
	end

	always_ff @(posedge clk) begin
		if (en[13]) begin
			acc_s14 <= ACC_W'(term[0]) + ACC_W'(term[1]) + ACC_W'(term[2])
				+ ACC_W'(term[3]);
		end
	end

	assign sh_d = acc_s14 >>> (INT_FRAC - FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en[14]) begin
			if (sh_d > OUT_MAX) res_s15 <= OUT_MAX[OUT_W-1:0];
			else if (sh_d < OUT_MIN) res_s15 <= OUT_MIN[OUT_W-1:0];
			else res_s15 <= sh_d[OUT_W-1:0];
		end
	end

`ifndef NO_ASSERTIONS
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		coord_valid && !coord_stall |=> v_q[0])
		else $error("accepted request did not enter the first stage");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		coord_stall |-> noise_valid && noise_stall)
		else $error("input stalled while the output end can move");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!(coord_valid && !coord_stall) && noise_valid && !noise_stall
		|=> $countones(v_q) == $past($countones(v_q)) - 1)
		else $error("request count in the pipeline is off after a delivery");
`endif

endmodule
`default_nettype wire

FILE: verif/simplex_noise_3d_top_tb.sv
// Testbench for simplex_noise_3d_top: streams points, predicts the noise value
// of each and checks every result in order. Depends on snd_pkg and the rtl.
`timescale 1ns / 1ps
module simplex_noise_3d_top_tb;
	import snd_pkg::*;

	localparam int FRAC = 16;
	localparam int LIMIT_CYCLES = 400000;
	localparam int HASH_TAB_I [8] = '{21, 56, 50, 44, 13, 19, 7, 42};
	localparam longint T_MAX = 161061274;

	logic clk, arst_n;
	logic coord_valid, coord_stall, noise_valid, noise_stall;
	logic signed [COORD_W-1:0] coord_x, coord_y, coord_z;
	logic signed [OUT_W-1:0] noise_value;

	int send_idle_pct, recv_stall_pct;
	bit hold_off;
	int errors;
	longint cycles;
	logic signed [OUT_W-1:0] noise_q[$];

	simplex_noise_3d_top #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .coord_valid(coord_valid), .coord_stall(coord_stall),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.noise_valid(noise_valid), .noise_stall(noise_stall), .noise_value(noise_value)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		return q;
	endfunction

	function automatic longint fshr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic int pick(longint p, longint q, longint r, int pos);
		return HASH_TAB_I[{p[pos], q[pos], r[pos]}];
	endfunction

	function automatic longint lattice_hash(longint p, longint q, longint r);
		return pick(p, q, r, 0) + pick(q, r, p, 1) + pick(r, p, q, 2) + pick(p, q, r, 3)
			+ pick(q, r, p, 4) + pick(r, p, q, 5) + pick(p, q, r, 6) + pick(q, r, p, 7);
	endfunction

	function automatic logic signed [OUT_W-1:0] noise_at(longint x, longint y, longint z);
		longint unit, s, cx, cy, cz, cs, d[3], stp[3], acc, res;
		longint as, ex, ey, ez, ox, oy, oz, h, sq, t, t2, t4, p, q, r, g;
		logic [63:0] hb, u;
		int hi, lo, mid, ord[4], sel;
		unit = 64'sd1 << FRAC;
		s = x + y + z;
		cx = fdiv(3 * x + s, 3 * unit);
		cy = fdiv(3 * y + s, 3 * unit);
		cz = fdiv(3 * z + s, 3 * unit);
		cs = cx + cy + cz;
		d[0] = 6 * x - 6 * cx * unit + cs * unit;
		d[1] = 6 * y - 6 * cy * unit + cs * unit;
		d[2] = 6 * z - 6 * cz * unit + cs * unit;
		if (d[0] >= d[2]) hi = (d[0] >= d[1]) ? 0 : 1;
		else hi = (d[1] >= d[2]) ? 1 : 2;
		if (d[0] < d[2]) lo = (d[0] < d[1]) ? 0 : 1;
		else lo = (d[1] < d[2]) ? 1 : 2;
		mid = 3 - hi - lo;
		if (mid > 2 || mid < 0) mid = 2;
		ord = '{hi, mid, lo, 0};
		stp = '{0, 0, 0};
		acc = 0;
		for (int c = 0; c < 4; c++) begin
			as = stp[0] + stp[1] + stp[2];
			ex = d[0] - 6 * stp[0] * unit + as * unit;
			ey = d[1] - 6 * stp[1] * unit + as * unit;
			ez = d[2] - 6 * stp[2] * unit + as * unit;
			ox = fdiv(ex * (64'sd1 << (28 - FRAC)), 6);
			oy = fdiv(ey * (64'sd1 << (28 - FRAC)), 6);
			oz = fdiv(ez * (64'sd1 << (28 - FRAC)), 6);
			h = lattice_hash(cx + stp[0], cy + stp[1], cz + stp[2]);
			sq = ox * ox + oy * oy + oz * oz;
			stp[ord[c]]++;
			u = sq;
			t = T_MAX - longint'(u >> 28);
			if (t < 0)
				continue;
			hb = h;
			sel = hb[1:0];
			if (sel == 1) begin p = ox; q = oy; r = oz; end
			else if (sel == 2) begin p = oy; q = oz; r = ox; end
			else begin p = oz; q = ox; r = oy; end
			if (hb[5] == hb[3]) p = -p;
			if (hb[5] == hb[4]) q = -q;
			if (hb[5] != (hb[4] ^ hb[3])) r = -r;
			if (sel == 0) g = p + q + r;
			else if (!hb[2]) g = p + q;
			else g = p + r;
			u = t * t;
			t2 = longint'(u >> 28);
			u = t2 * t2;
			t4 = longint'(u >> 28);
			acc += fshr(t4 * g, 25);
		end
		res = fshr(acc, 28 - FRAC);
		if (res > 262143) res = 262143;
		if (res < -262144) res = -262144;
		return res[OUT_W-1:0];
	endfunction

	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			coord_valid <= 1'b0;
			@(posedge clk);
		end
		coord_valid <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		noise_q.push_back(noise_at(x, y, z));
		@(posedge clk);
		while (coord_stall) @(posedge clk);
	endtask

	task automatic go_quiet();
		coord_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(20 << 16) - (10 << 16);
			2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
			default: return ($urandom_range(200) - 100) << 16;
		endcase
	endfunction

	task automatic test_directed();
		logic signed [31:0] ext[6];
		ext = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh00010000, 32'shffff0000, 32'sh00008000};
		foreach (ext[i]) send_point(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6]);
		send_point(0, 0, 0);
		send_point(3 << 16, 5 << 16, -7 << 16);
		send_point(32'sh5555, 32'sh5555, 32'sh5555);
		send_point(32'sh00004000, 32'sh0000c000, 32'sh00002000);
		send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_point(32'shffffffff, 1, 32'shfffffffe);
		send_point(32'sh000a1234, 32'sh0003abcd, 32'sh00019876);
		go_quiet();
	endtask

	task automatic test_random(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) send_point(rand_coord(), rand_coord(), rand_coord());
		go_quiet();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b1;
		repeat (60) send_point(rand_coord(), rand_coord(), rand_coord());
		go_quiet();
	endtask

	always @(posedge clk) begin
		int hold_cnt;
		if (hold_off) begin
			hold_cnt++;
			if (hold_cnt >= 200) begin
				hold_off <= 1'b0;
				hold_cnt = 0;
			end
			noise_stall <= 1'b1;
		end else
			noise_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		logic signed [OUT_W-1:0] want;
		if (arst_n && noise_valid && !noise_stall) begin
			if (noise_q.size() == 0) begin
				$error("noise_value: no request outstanding, actual %0d", noise_value);
				errors++;
			end else begin
				want = noise_q.pop_front();
				if (noise_value !== want) begin
					$error("noise_value: expected %0d actual %0d", want, noise_value);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		coord_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		noise_stall = 1'b0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		errors = 0;
		cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(480, 0, 0);
		test_backpressure();
		test_random(460, 63, 0);
		test_random(460, 0, 63);
		test_random(460, 31, 31);
		recv_stall_pct = 0;
		while (noise_q.size() != 0) @(posedge clk);
		repeat (NSTAGE + 10) @(posedge clk);
		if (errors == 0 && noise_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/snd_pkg.sv
rtl/snd_skew.sv
rtl/snd_offset.sv
rtl/snd_corner.sv
rtl/simplex_noise_3d_top.sv
verif/simplex_noise_3d_top_tb.sv
